// ===== src/rlsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlsd_pkg
// Shared types and codes for the run-length stream decoder.
// ----------------------------------------------------------------------------
package rlsd_pkg;

	localparam int unsigned CfgWidth = 32;
	localparam logic [CfgWidth-1:0] MaxOutputLengthReset = '1;

	localparam logic [2:0] ERR_OK       = 3'd0;
	localparam logic [2:0] ERR_OPTION   = 3'd1;
	localparam logic [2:0] ERR_CAPACITY = 3'd2;
	localparam logic [2:0] ERR_TRUNC    = 3'd3;
	localparam logic [2:0] ERR_OVERRUN  = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [7:0] run_value;
		logic [7:0] run_count;
		logic       last_run;
		logic [2:0] error_code;
	} out_item_t;

	// Result from the decoder core toward the result register
	typedef struct packed {
		logic      valid;
		out_item_t item;
	} core_res_t;

endpackage
`default_nettype wire

// ===== src/rlsd_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlsd_in_if
// Compressed byte channel: valid/ready with one byte and its end mark.
// ----------------------------------------------------------------------------
interface rlsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_input;

	modport source (output valid, output data_byte, output end_of_input, input ready);
	modport sink (input valid, input data_byte, input end_of_input, output ready);
endinterface
`default_nettype wire

// ===== src/rlsd_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlsd_out_if
// Run descriptor channel: valid/ready with value, count, last and error.
// ----------------------------------------------------------------------------
interface rlsd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] run_value;
	logic [7:0] run_count;
	logic       last_run;
	logic [2:0] error_code;

	modport source (output valid, output run_value, output run_count, output last_run,
		output error_code, input ready);
	modport sink (input valid, input run_value, input run_count, input last_run,
		input error_code, output ready);
endinterface
`default_nettype wire

// ===== src/rlsd_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlsd_in_stage
// Input register: holds one accepted byte until the core consumes it.
// ----------------------------------------------------------------------------
module rlsd_in_stage
	import rlsd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	rlsd_in_if.sink       in_ch,
	input  wire logic     take,
	output logic          valid_s1,
	output in_item_t      item_s1
);

	logic accept;

	assign in_ch.ready = !valid_s1 || take;
	assign accept      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.data_byte    <= in_ch.data_byte;
			item_s1.end_of_input <= in_ch.end_of_input;
		end
	end

endmodule
`default_nettype wire

// ===== src/rlsd_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlsd_core
// Decoder state: header parse, flag handling, run emission, error checks.
// ----------------------------------------------------------------------------
module rlsd_core
	import rlsd_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CfgWidth-1:0] cfg_wdata,
	input  wire logic                take,
	input  wire in_item_t            item,
	output core_res_t                res
);

	typedef enum logic [2:0] {
		PH_HDR0    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_FLAG    = 3'd2,
		PH_REPEAT  = 3'd3,
		PH_LITERAL = 3'd4,
		PH_IDLE    = 3'd5
	} phase_t;

	phase_t        phase_q, phase_d;
	logic [23:0]   hdr_q, hdr_d;
	logic [1:0]    idx_q, idx_d;
	logic [31:0]   rem_q, rem_d;
	logic [7:0]    lit_q, lit_d;
	logic [7:0]    rep_q, rep_d;
	logic [CfgWidth-1:0] max_q;

	logic [7:0]  b;
	logic        eoi;
	logic [31:0] word;
	logic [31:0] size_sel;
	logic [31:0] rem_rep;
	logic [31:0] rem_lit;
	logic [7:0]  run_len;

	assign b        = item.data_byte;
	assign eoi      = item.end_of_input;
	assign word     = {b, hdr_q};
	assign size_sel = (phase_q == PH_HDR1) ? word : {8'd0, word[31:8]};
	assign rem_rep  = rem_q - {24'd0, rep_q};
	assign rem_lit  = rem_q - 32'd1;
	assign run_len  = b[7] ? ({1'b0, b[6:0]} + 8'd3) : ({1'b0, b[6:0]} + 8'd1);

	always_comb begin
		phase_d = phase_q;
		hdr_d   = hdr_q;
		idx_d   = idx_q;
		rem_d   = rem_q;
		lit_d   = lit_q;
		rep_d   = rep_q;
		res     = '0;

		unique case (phase_q)
			PH_HDR0, PH_HDR1: begin
				if (idx_q != 2'd3) begin
					idx_d = idx_q + 2'd1;
					hdr_d[{idx_q, 3'b000} +: 8] = b;
					if (eoi) begin
						phase_d = PH_IDLE;
						res.valid = 1'b1;
						res.item.error_code = ERR_TRUNC;
					end
				end else begin
					idx_d = 2'd0;
					hdr_d = '0;
					if (phase_q == PH_HDR0 && word[3:0] != 4'd0) begin
						phase_d = PH_IDLE;
						res.valid = 1'b1;
						res.item.error_code = ERR_OPTION;
					end else if (phase_q == PH_HDR0 && word[31:8] == 24'd0) begin
						// 24-bit size of zero: real size follows in a second word
						if (eoi) begin
							phase_d = PH_IDLE;
							res.valid = 1'b1;
							res.item.error_code = ERR_TRUNC;
						end else begin
							phase_d = PH_HDR1;
						end
					end else if (size_sel > max_q) begin
						phase_d = PH_IDLE;
						res.valid = 1'b1;
						res.item.error_code = ERR_CAPACITY;
					end else if (size_sel == 32'd0) begin
						phase_d = PH_IDLE;
						res.valid = 1'b1;
						res.item.last_run = 1'b1;
					end else if (eoi) begin
						phase_d = PH_IDLE;
						res.valid = 1'b1;
						res.item.error_code = ERR_TRUNC;
					end else begin
						rem_d   = size_sel;
						phase_d = PH_FLAG;
					end
				end
			end
			PH_FLAG: begin
				if (eoi) begin
					phase_d = PH_IDLE;
					res.valid = 1'b1;
					res.item.error_code = ERR_TRUNC;
				end else if ({24'd0, run_len} > rem_q) begin
					phase_d = PH_IDLE;
					res.valid = 1'b1;
					res.item.error_code = ERR_OVERRUN;
				end else if (b[7]) begin
					rep_d   = run_len;
					phase_d = PH_REPEAT;
				end else begin
					lit_d   = run_len;
					phase_d = PH_LITERAL;
				end
			end
			PH_REPEAT: begin
				rem_d = rem_rep;
				res.valid = 1'b1;
				if (eoi && rem_rep != 32'd0) begin
					phase_d = PH_IDLE;
					res.item.error_code = ERR_TRUNC;
				end else begin
					phase_d = (rem_rep == 32'd0) ? PH_IDLE : PH_FLAG;
					res.item.run_value = b;
					res.item.run_count = rep_q;
					res.item.last_run  = (rem_rep == 32'd0);
				end
			end
			PH_LITERAL: begin
				rem_d = rem_lit;
				lit_d = lit_q - 8'd1;
				res.valid = 1'b1;
				if (eoi && rem_lit != 32'd0) begin
					phase_d = PH_IDLE;
					res.item.error_code = ERR_TRUNC;
				end else begin
					if (rem_lit == 32'd0) begin
						phase_d = PH_IDLE;
					end else if (lit_q == 8'd1) begin
						phase_d = PH_FLAG;
					end
					res.item.run_value = b;
					res.item.run_count = 8'd1;
					res.item.last_run  = (rem_lit == 32'd0);
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase

		// end of stream rearms for a new header
		if (eoi) begin
			phase_d = PH_HDR0;
			hdr_d   = '0;
			idx_d   = 2'd0;
			rem_d   = '0;
			lit_d   = '0;
			rep_d   = '0;
		end

		if (!take) begin
			res.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			hdr_q   <= '0;
			idx_q   <= '0;
			rem_q   <= '0;
			lit_q   <= '0;
			rep_q   <= '0;
			max_q   <= MaxOutputLengthReset;
		end else begin
			if (take) begin
				phase_q <= phase_d;
				hdr_q   <= hdr_d;
				idx_q   <= idx_d;
				rem_q   <= rem_d;
				lit_q   <= lit_d;
				rep_q   <= rep_d;
			end
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/rlsd_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlsd_out_stage
// Result register: holds one run descriptor until the sink takes it.
// ----------------------------------------------------------------------------
module rlsd_out_stage
	import rlsd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire core_res_t res,
	input  wire logic     take,
	output logic          room,
	rlsd_out_if.source    out_ch
);

	logic      valid_q;
	out_item_t item_q;

	assign room = !valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= res.valid;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res.valid) begin
			item_q <= res.item;
		end
	end

	assign out_ch.valid      = valid_q;
	assign out_ch.run_value  = item_q.run_value;
	assign out_ch.run_count  = item_q.run_count;
	assign out_ch.last_run   = item_q.last_run;
	assign out_ch.error_code = item_q.error_code;

endmodule
`default_nettype wire

// ===== src/run_length_stream_decoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted byte waits in the input register, then is decoded into the result
// register; a held result that blocks the output delays it.
// Throughput: one byte per cycle; the input register drains whenever the
// result register is empty or being read in the same cycle.
// Reset: clears decoder state to header parse, capacity to all ones.
// ----------------------------------------------------------------------------
// run_length_stream_decoder_unit
// Decodes an RLE compressed byte stream into run descriptors.
// ----------------------------------------------------------------------------
module run_length_stream_decoder_unit
	import rlsd_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	rlsd_in_if.sink                  in_ch,
	rlsd_out_if.source               out_ch,
	input  wire logic                cfg_we,
	input  wire logic [CfgWidth-1:0] cfg_wdata
);

	logic      valid_s1;
	in_item_t  item_s1;
	logic      room;
	logic      take;
	core_res_t res;

	assign take = valid_s1 && room;

	rlsd_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	rlsd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.take      (take),
		.item      (item_s1),
		.res       (res)
	);

	rlsd_out_stage u_out_stage (
		.clk    (clk),
		.arst_n (arst_n),
		.res    (res),
		.take   (take),
		.room   (room),
		.out_ch (out_ch)
	);

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the run-length stream decoder unit. Compressed
// streams (well-formed, truncated, overrunning, bad header, noise) are pushed
// through the byte channel with random gaps and back-pressure; a bit-exact
// decoder model predicts every run descriptor and a scoreboard checks them
// in order. The output capacity register is changed between idle phases.
// ----------------------------------------------------------------------------

import rlsd_pkg::*;

typedef enum logic [2:0] {
	P_HEADER,
	P_SIZE_WORD,
	P_FLAG,
	P_REPEAT,
	P_LITERAL,
	P_DRAIN
} rle_phase_e;

class run_scoreboard;
	logic [31:0] capacity;
	rle_phase_e  phase;
	logic [31:0] hdr_word;
	logic [1:0]  hdr_idx;
	logic [31:0] out_left;
	logic [7:0]  lit_left;
	logic [7:0]  rep_len;
	out_item_t   expected_runs[$];
	int unsigned errors;

	function new();
		capacity = MaxOutputLengthReset;
		errors = 0;
		clear_decoder();
	endfunction

	function void clear_decoder();
		phase = P_HEADER;
		hdr_word = '0;
		hdr_idx = '0;
		out_left = '0;
		lit_left = '0;
		rep_len = '0;
	endfunction

	function void set_capacity(logic [31:0] v);
		capacity = v;
	endfunction

	function int unsigned pending();
		return expected_runs.size();
	endfunction

	function out_item_t mk_run(logic [7:0] v, logic [7:0] c, logic l, logic [2:0] e);
		out_item_t r;
		r.run_value = v;
		r.run_count = c;
		r.last_run = l;
		r.error_code = e;
		return r;
	endfunction

	function out_item_t abort(logic [2:0] e);
		phase = P_DRAIN;
		return mk_run(8'd0, 8'd0, 1'b0, e);
	endfunction

	// Declared size is known: capacity first, then empty output, then early end.
	function bit take_size(logic [31:0] size, logic eoi, output out_item_t r);
		if (size > capacity) begin
			r = abort(ERR_CAPACITY);
			return 1'b1;
		end
		if (size == 0) begin
			phase = P_DRAIN;
			r = mk_run(8'd0, 8'd0, 1'b1, ERR_OK);
			return 1'b1;
		end
		if (eoi) begin
			r = abort(ERR_TRUNC);
			return 1'b1;
		end
		out_left = size;
		phase = P_FLAG;
		return 1'b0;
	endfunction

	function bit decode_byte(logic [7:0] b, logic eoi, output out_item_t r);
		logic [31:0] word;
		logic [7:0]  n;
		bit          hit;
		hit = 1'b0;
		r = '0;
		case (phase)
			P_HEADER, P_SIZE_WORD: begin
				word = hdr_word | ({24'd0, b} << {hdr_idx, 3'b000});
				if (hdr_idx != 2'd3) begin
					hdr_word = word;
					hdr_idx = hdr_idx + 2'd1;
					if (eoi) begin
						r = abort(ERR_TRUNC);
						hit = 1'b1;
					end
				end else begin
					hdr_word = '0;
					hdr_idx = '0;
					if (phase == P_SIZE_WORD) begin
						hit = take_size(word, eoi, r);
					end else if (word[3:0] != 4'd0) begin
						r = abort(ERR_OPTION);
						hit = 1'b1;
					end else if (word[31:8] == 24'd0) begin
						if (eoi) begin
							r = abort(ERR_TRUNC);
							hit = 1'b1;
						end else begin
							phase = P_SIZE_WORD;
						end
					end else begin
						hit = take_size({8'd0, word[31:8]}, eoi, r);
					end
				end
			end
			P_FLAG: begin
				if (eoi) begin
					r = abort(ERR_TRUNC);
					hit = 1'b1;
				end else if (b[7]) begin
					n = {1'b0, b[6:0]} + 8'd3;
					if ({24'd0, n} > out_left) begin
						r = abort(ERR_OVERRUN);
						hit = 1'b1;
					end else begin
						rep_len = n;
						phase = P_REPEAT;
					end
				end else begin
					n = {1'b0, b[6:0]} + 8'd1;
					if ({24'd0, n} > out_left) begin
						r = abort(ERR_OVERRUN);
						hit = 1'b1;
					end else begin
						lit_left = n;
						phase = P_LITERAL;
					end
				end
			end
			P_REPEAT: begin
				out_left = out_left - {24'd0, rep_len};
				hit = 1'b1;
				if (eoi && out_left != 0) begin
					r = abort(ERR_TRUNC);
				end else begin
					phase = (out_left == 0) ? P_DRAIN : P_FLAG;
					r = mk_run(b, rep_len, out_left == 0, ERR_OK);
				end
			end
			P_LITERAL: begin
				out_left = out_left - 32'd1;
				lit_left = lit_left - 8'd1;
				hit = 1'b1;
				if (eoi && out_left != 0) begin
					r = abort(ERR_TRUNC);
				end else begin
					if (out_left == 0)
						phase = P_DRAIN;
					else if (lit_left == 0)
						phase = P_FLAG;
					r = mk_run(b, 8'd1, out_left == 0, ERR_OK);
				end
			end
			default: phase = P_DRAIN;
		endcase
		// end of input always rearms the header parse
		if (eoi)
			clear_decoder();
		return hit;
	endfunction

	function void note_byte(logic [7:0] b, logic eoi);
		out_item_t r;
		if (decode_byte(b, eoi, r))
			expected_runs.push_back(r);
	endfunction

	function void check_run(out_item_t got);
		out_item_t want;
		if (expected_runs.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected run: value %02h count %0d last %0b err %0d",
					got.run_value, got.run_count, got.last_run, got.error_code);
			return;
		end
		want = expected_runs.pop_front();
		if (got.run_value !== want.run_value || got.run_count !== want.run_count ||
				got.last_run !== want.last_run || got.error_code !== want.error_code) begin
			errors++;
			if (errors <= 10)
				$display("run mismatch: exp %02h/%0d/%0b/%0d got %02h/%0d/%0b/%0d",
					want.run_value, want.run_count, want.last_run, want.error_code,
					got.run_value, got.run_count, got.last_run, got.error_code);
		end
	endfunction
endclass

module tb;
	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	rlsd_in_if  in_ch();
	rlsd_out_if out_ch();

	run_length_stream_decoder_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	run_scoreboard sb;
	logic [7:0]    stream_q[$];
	int unsigned   bytes_sent = 0;
	bit            gap_on = 1'b0;
	bit            hold_req = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin : watchdog
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic void push_word(logic [31:0] w);
		for (int i = 0; i < 4; i++)
			stream_q.push_back(w[8*i +: 8]);
	endfunction

	function automatic void push_noise(int unsigned lo, int unsigned hi);
		int unsigned cnt;
		cnt = $urandom_range(lo, hi);
		for (int i = 0; i < cnt; i++)
			stream_q.push_back(8'($urandom_range(0, 255)));
	endfunction

	function automatic void push_header(logic [31:0] size, bit wide);
		logic [3:0] nib;
		nib = 4'($urandom_range(0, 15));
		if (wide) begin
			push_word({24'd0, nib, 4'h0});
			push_word(size);
		end else begin
			push_word({size[23:0], nib, 4'h0});
		end
	endfunction

	// Flag/data runs covering size bytes; with overrun set, one flag may claim
	// more than what is left, and the stream then ends in junk.
	function automatic void push_runs(int unsigned size, bit overrun);
		int unsigned left, n, max_n, at, lo;
		left = size;
		at = $urandom_range(0, 3);
		while (left > 0) begin
			if (overrun && at == 0 && left < 130) begin
				if (left < 128 && $urandom_range(0, 1)) begin
					n = $urandom_range(left + 1, 128);
					stream_q.push_back(8'(n - 1));
				end else begin
					lo = (left + 1 < 3) ? 3 : left + 1;
					n = $urandom_range(lo, 130);
					stream_q.push_back(8'h80 | 8'(n - 3));
				end
				push_noise(1, 3);
				return;
			end
			if (at > 0)
				at--;
			if (left >= 3 && $urandom_range(0, 1)) begin
				max_n = (left < 130) ? left : 130;
				n = ($urandom_range(0, 7) == 0) ? max_n :
					$urandom_range(3, (max_n < 11) ? max_n : 11);
				stream_q.push_back(8'h80 | 8'(n - 3));
				stream_q.push_back(8'($urandom_range(0, 255)));
			end else begin
				max_n = (left < 128) ? left : 128;
				n = ($urandom_range(0, 7) == 0) ? max_n :
					$urandom_range(1, (max_n < 6) ? max_n : 6);
				stream_q.push_back(8'(n - 1));
				for (int i = 0; i < n; i++)
					stream_q.push_back(8'($urandom_range(0, 255)));
			end
			left -= n;
		end
	endfunction

	function automatic void build_random_stream();
		int unsigned kind, size, keep;
		stream_q.delete();
		kind = $urandom_range(0, 99);
		size = ($urandom_range(0, 99) < 88) ? $urandom_range(1, 40) : $urandom_range(100, 300);
		if (kind < 62) begin
			push_header(size, $urandom_range(0, 4) == 0);
			push_runs(size, 1'b0);
			if ($urandom_range(0, 6) == 0)
				push_noise(1, 3);
		end else if (kind < 70) begin
			push_header(32'd0, 1'b1);
			if ($urandom_range(0, 2) == 0)
				push_noise(1, 3);
		end else if (kind < 78) begin
			push_header(size, $urandom_range(0, 4) == 0);
			push_runs(size, 1'b0);
			keep = $urandom_range(1, stream_q.size() - 1);
			while (stream_q.size() > keep)
				void'(stream_q.pop_back());
		end else if (kind < 86) begin
			push_header(size, $urandom_range(0, 4) == 0);
			push_runs(size, 1'b1);
		end else if (kind < 90) begin
			push_word({24'($urandom), 4'($urandom_range(0, 15)), 4'($urandom_range(1, 15))});
			push_noise(0, 4);
		end else if (kind < 94) begin
			if ($urandom_range(0, 1))
				push_header($urandom_range(1, 32'hFFFF_FFFF), 1'b1);
			else
				push_header($urandom_range(1, 24'hFF_FFFF), 1'b0);
			push_noise(1, 6);
		end else begin
			push_noise(1, 8);
		end
	endfunction

	task automatic send_byte(logic [7:0] b, logic eoi);
		int unsigned gap;
		gap = gap_on ? $urandom_range(0, 11) : 0;
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.end_of_input <= eoi;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		sb.note_byte(b, eoi);
		bytes_sent++;
	endtask

	task automatic send_stream();
		gap_on = ($urandom_range(0, 2) != 0);
		foreach (stream_q[i])
			send_byte(stream_q[i], i == stream_q.size() - 1);
	endtask

	// Lower valid and let every predicted run drain out.
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(logic [31:0] v);
		wait_drained();
		// a byte that gives no run may still sit in the pipeline
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		sb.set_capacity(v);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : result_sink
		int unsigned stall, taken;
		bit          calm;
		out_item_t   got;
		taken = 0;
		calm = 1'b1;
		out_ch.ready <= 1'b0;
		forever begin
			if (taken % 32 == 0)
				calm = ($urandom_range(0, 2) == 0);
			stall = calm ? 0 : $urandom_range(0, 11);
			if (hold_req) begin
				hold_req = 1'b0;
				stall = 300;
			end
			if (stall != 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (out_ch.valid !== 1'b1);
			got.run_value = out_ch.run_value;
			got.run_count = out_ch.run_count;
			got.last_run = out_ch.last_run;
			got.error_code = out_ch.error_code;
			sb.check_run(got);
			taken++;
		end
	end

	initial begin : stimulus
		int unsigned target;
		bit          hold_done, pause_done;
		logic [31:0] cap;
		sb = new();
		hold_done = 1'b0;
		pause_done = 1'b0;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.data_byte <= 8'd0;
		in_ch.end_of_input <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 32'd0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// header cut short after one byte
		stream_q = '{8'h30};
		send_stream();
		// option nibble wins over the early end
		stream_q = '{8'h31, 8'h00, 8'h00, 8'h00};
		send_stream();
		// zero 24-bit size with the input ending there
		stream_q = '{8'h30, 8'h00, 8'h00, 8'h00};
		send_stream();
		// zero size from the second word, input ends on it
		stream_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		send_stream();
		// a repeat run of three FF, then one literal 00
		stream_q = '{8'hF0, 8'h04, 8'h00, 8'h00, 8'h80, 8'hFF, 8'h00, 8'h00};
		send_stream();

		for (int p = 0; p < 5; p++) begin
			if (p != 0) begin
				case (p)
					1: cap = 32'd0;
					2: cap = $urandom_range(8, 60);
					3: cap = 32'hFFFF_FFFF;
					default: cap = $urandom_range(0, 300);
				endcase
				write_capacity(cap);
			end
			target = 25 + (p + 1) * 205;
			while (bytes_sent < target) begin
				build_random_stream();
				send_stream();
				if (!hold_done && bytes_sent >= 100) begin
					hold_done = 1'b1;
					hold_req = 1'b1;
				end
				if (!pause_done && p == 3 && bytes_sent >= 740) begin
					pause_done = 1'b1;
					wait_drained();
				end
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
